[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, payload words, state encoding and the control/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Field widths fixed by the interface.
  localparam int CURSOR_W = 11;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Operation codes.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Attribute reset values.
  localparam logic [7:0] RESET_TEXT_ATTR  = 8'h0F;
  localparam logic [7:0] RESET_BLANK_ATTR = 8'h07;

  // Register indexes, taken from address bit 2.
  localparam logic REG_TEXT_ATTR  = 1'b0;
  localparam logic REG_BLANK_ATTR = 1'b1;

  // Input word.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_word_t;

  // Result word.
  typedef struct packed {
    logic [15:0]         cell_value;
    logic [CURSOR_W-1:0] cursor_position;
    logic                scrolled;
  } rsp_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_RESET_FILL,
    ST_IDLE,
    ST_DECODE,
    ST_COPY,
    ST_FILL,
    ST_RESPOND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;        // capture the input word
    logic do_put;        // write the character and move the cursor
    logic copy_start;    // start the scroll copy at cell 0
    logic copy_step;     // move one cell up by one row
    logic clear_start;   // start a full-screen fill and home the cursor
    logic bottom_start;  // start the fill of the bottom row
    logic fill_step;     // write one blank cell
    logic fill_default;  // blanks use the reset attribute
    logic read_issue;    // read the requested cell
    logic respond;       // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       put_scrolls;
    logic       copy_done;
    logic       fill_done;
    logic       rsp_free;
  } dp_status_t;

endpackage

[rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// Text console writer top level
// Character console with a screen store, cursor, scrolling and clear.
//
//   Channel   Direction  Handshake                 Word
//   cmd       in         cmd_valid / cmd_ready     cmd_word_t (op, char, index)
//   rsp       out        rsp_valid / rsp_ready     rsp_word_t (cell, cursor, scroll)
//   apb       in/out     psel, penable, pready     text and blank attributes
//
// One word is worked on at a time. A put that scrolls copies the screen up
// one row and then fills the bottom row, both through the single write port
// of the screen memory; a clear fills every cell. After reset the store is
// blanked, during which no command word is taken. A waiting result does not
// block the next command word from being accepted.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  tcw_pkg::cmd_word_t          cmd_data,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output tcw_pkg::rsp_word_t          rsp_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [7:0]           text_attr;
  logic [7:0]           blank_attr;
  tcw_pkg::ctrl_cmd_t   ctrl_cmd;
  tcw_pkg::dp_status_t  dp_status;

  // Configuration registers.
  tcw_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_attr  (text_attr),
    .blank_attr (blank_attr)
  );

  // Sequencer.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  // Screen store and cursor.
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctrl_cmd),
    .status     (dp_status),
    .cmd_data   (cmd_data),
    .rsp_data   (rsp_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .text_attr  (text_attr),
    .blank_attr (blank_attr)
  );

endmodule

[rtl/tcw_regs.sv]
// ----------------------------------------------------------------------------
// Text console writer configuration registers
// APB-style register file holding the text and blank attributes.
// ----------------------------------------------------------------------------
module tcw_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [7:0]                  text_attr,
  output logic [7:0]                  blank_attr
);

  logic wr_en;

  // The port never stalls, so a write lands in the access cycle.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= tcw_pkg::RESET_TEXT_ATTR;
      blank_attr <= tcw_pkg::RESET_BLANK_ATTR;
    end else if (wr_en) begin
      case (paddr[2])
        tcw_pkg::REG_TEXT_ATTR:  text_attr  <= pwdata[7:0];
        tcw_pkg::REG_BLANK_ATTR: blank_attr <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (paddr[2])
      tcw_pkg::REG_TEXT_ATTR:  prdata = {(tcw_pkg::APB_DW - 8)'(0), text_attr};
      tcw_pkg::REG_BLANK_ATTR: prdata = {(tcw_pkg::APB_DW - 8)'(0), blank_attr};
      default:                 prdata = '0;
    endcase
  end

endmodule

[rtl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory, cursor registers, sweep counter and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tcw_pkg::ctrl_cmd_t    cmd,
  output tcw_pkg::dp_status_t   status,
  input  tcw_pkg::cmd_word_t    cmd_data,
  output tcw_pkg::rsp_word_t    rsp_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  logic [7:0]            text_attr,
  input  logic [7:0]            blank_attr
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int CELL_AW    = $clog2(CELLS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  logic [15:0]              mem [CELLS];
  logic [15:0]              rd_data;
  logic                     we;
  logic                     re;
  logic [CELL_AW-1:0]       waddr;
  logic [CELL_AW-1:0]       raddr;
  logic [15:0]              wdata;

  tcw_pkg::cmd_word_t       word;
  logic [CELL_AW-1:0]       cnt;
  logic [CELL_AW-1:0]       cnt_next;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  logic [CELL_AW-1:0]       pos;
  logic                     scrolled;

  logic                     is_newline;
  logic                     is_return;
  logic                     last_col;
  logic                     last_row;
  logic                     in_range;
  logic [7:0]               fill_attr;

  // Decode of the captured word and cursor.
  assign is_newline = (word.char_code == tcw_pkg::CHAR_NEWLINE);
  assign is_return  = (word.char_code == tcw_pkg::CHAR_RETURN);
  assign last_col   = (col == COL_W'(COLUMNS - 1));
  assign last_row   = (row == ROW_W'(ROWS - 1));
  assign in_range   = (int'(word.cell_index) < CELLS);
  assign fill_attr  = cmd.fill_default ? tcw_pkg::RESET_BLANK_ATTR : blank_attr;

  // Status back to the controller.
  assign status.op          = word.op;
  assign status.put_scrolls = last_row && (is_newline || (!is_return && last_col));
  assign status.copy_done   = (cnt == CELL_AW'(COPY_CELLS));
  assign status.fill_done   = (cnt == CELL_AW'(CELLS - 1));
  assign status.rsp_free    = !rsp_valid || rsp_ready;

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt;
    raddr = cnt + CELL_AW'(COLUMNS);
    wdata = rd_data;
    if (cmd.do_put && !is_newline && !is_return) begin
      we    = 1'b1;
      waddr = pos;
      wdata = {text_attr, word.char_code};
    end
    if (cmd.copy_step) begin
      // Write the cell fetched last cycle one row higher, fetch the next one.
      if (cnt != '0) begin
        we    = 1'b1;
        waddr = cnt - CELL_AW'(1);
        wdata = rd_data;
      end
      re = !status.copy_done;
    end
    if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = {fill_attr, tcw_pkg::CHAR_SPACE};
    end
    if (cmd.read_issue) begin
      re    = in_range;
      raddr = CELL_AW'(word.cell_index);
    end
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  // Sweep counter for copy and fill passes.
  always_comb begin
    cnt_next = cnt;
    if (cmd.copy_step || cmd.fill_step) begin
      cnt_next = cnt + CELL_AW'(1);
    end
    if (cmd.copy_start || cmd.clear_start) begin
      cnt_next = '0;
    end
    if (cmd.bottom_start) begin
      cnt_next = CELL_AW'(COPY_CELLS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word <= cmd_data;
    end
  end

  // Cursor update. The linear position is tracked beside column and row.
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pos      <= '0;
      scrolled <= 1'b0;
    end else begin
      if (cmd.accept) begin
        scrolled <= 1'b0;
      end
      if (cmd.clear_start) begin
        col <= '0;
        row <= '0;
        pos <= '0;
      end
      if (cmd.do_put) begin
        scrolled <= status.put_scrolls;
        if (is_newline) begin
          col <= '0;
          if (last_row) begin
            pos <= CELL_AW'(COPY_CELLS);
          end else begin
            row <= row + ROW_W'(1);
            pos <= pos - CELL_AW'(col) + CELL_AW'(COLUMNS);
          end
        end else if (is_return) begin
          col <= '0;
          pos <= pos - CELL_AW'(col);
        end else if (last_col) begin
          col <= '0;
          if (last_row) begin
            pos <= CELL_AW'(COPY_CELLS);
          end else begin
            row <= row + ROW_W'(1);
            pos <= pos + CELL_AW'(1);
          end
        end else begin
          col <= col + COL_W'(1);
          pos <= pos + CELL_AW'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.respond) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      rsp_data.cell_value      <= (word.op == tcw_pkg::OP_READ && in_range) ? rd_data : 16'h0;
      rsp_data.cursor_position <= tcw_pkg::CURSOR_W'(pos);
      rsp_data.scrolled        <= scrolled;
    end
  end

endmodule

[rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console writer controller
// State machine that sequences puts, scroll copies, fills and reads.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  tcw_pkg::dp_status_t  status,
  output tcw_pkg::ctrl_cmd_t   cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;

  // State register; reset starts the blanking pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_RESET_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_RESET_FILL: begin
        if (status.fill_done) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = tcw_pkg::ST_DECODE;
      end
      tcw_pkg::ST_DECODE: begin
        case (status.op)
          tcw_pkg::OP_PUT: begin
            state_next = status.put_scrolls ? tcw_pkg::ST_COPY : tcw_pkg::ST_RESPOND;
          end
          tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_FILL;
          default:           state_next = tcw_pkg::ST_RESPOND;
        endcase
      end
      tcw_pkg::ST_COPY: begin
        if (status.copy_done) state_next = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        if (status.fill_done) state_next = tcw_pkg::ST_RESPOND;
      end
      tcw_pkg::ST_RESPOND: begin
        if (status.rsp_free) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    cmd_ready = 1'b0;
    case (state)
      tcw_pkg::ST_RESET_FILL: begin
        cmd.fill_step    = 1'b1;
        cmd.fill_default = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        cmd_ready  = 1'b1;
        cmd.accept = cmd_valid;
      end
      tcw_pkg::ST_DECODE: begin
        case (status.op)
          tcw_pkg::OP_PUT: begin
            cmd.do_put     = 1'b1;
            cmd.copy_start = status.put_scrolls;
          end
          tcw_pkg::OP_CLEAR: cmd.clear_start = 1'b1;
          tcw_pkg::OP_READ:  cmd.read_issue  = 1'b1;
          default: ;
        endcase
      end
      tcw_pkg::ST_COPY: begin
        cmd.copy_step    = 1'b1;
        cmd.bottom_start = status.copy_done;
      end
      tcw_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      tcw_pkg::ST_RESPOND: begin
        cmd.respond = status.rsp_free;
      end
      default: ;
    endcase
  end

endmodule
